### hdl/sfr_pkg.sv
// Shared constants and types for the stuffed frame receiver.
// Used by sfr_parser, sfr_out_buf and stuffed_frame_receiver; no dependencies.
package sfr_pkg;

    localparam int MAX_PAYLOAD = 1024;
    localparam int LEN_W       = 11;

    // line bytes
    localparam logic [7:0] FLAG_BYTE = 8'h7e;
    localparam logic [7:0] ESC_BYTE  = 8'h7d;
    localparam logic [7:0] ADDR_BYTE = 8'h03;
    localparam logic [7:0] ESC_FLAG  = 8'h5e;
    localparam logic [7:0] ESC_ESC   = 8'h5d;

    // control bytes
    localparam logic [7:0] CTRL_SET  = 8'h03;
    localparam logic [7:0] CTRL_UA   = 8'h07;
    localparam logic [7:0] CTRL_DISC = 8'h0b;
    localparam logic [7:0] CTRL_I0   = 8'h00;
    localparam logic [7:0] CTRL_I1   = 8'h40;

    // event codes
    localparam logic [2:0] EV_DATA     = 3'd0;
    localparam logic [2:0] EV_SUP_OK   = 3'd1;
    localparam logic [2:0] EV_INFO_OK  = 3'd2;
    localparam logic [2:0] EV_DUP      = 3'd3;
    localparam logic [2:0] EV_INFO_ERR = 3'd4;

    // supervisory kinds
    localparam logic [1:0] KIND_SET  = 2'd0;
    localparam logic [1:0] KIND_UA   = 2'd1;
    localparam logic [1:0] KIND_DISC = 2'd2;

    // reply codes
    localparam logic [2:0] REP_NONE = 3'd0;
    localparam logic [2:0] REP_UA   = 3'd1;
    localparam logic [2:0] REP_RR0  = 3'd2;
    localparam logic [2:0] REP_RR1  = 3'd3;
    localparam logic [2:0] REP_REJ0 = 3'd4;
    localparam logic [2:0] REP_REJ1 = 3'd5;

    typedef struct packed {
        logic [2:0]       event_res;
        logic [7:0]       data_byte;
        logic [1:0]       frame_kind;
        logic             seq_number;
        logic [LEN_W-1:0] payload_length;
        logic [2:0]       reply;
    } sfr_item_t;

    typedef struct packed {
        logic      valid;
        sfr_item_t item;
    } sfr_result_t;

endpackage

### hdl/stuffed_frame_receiver.sv
// Stuffed frame receiver top level: byte stream in, frame events out.
// A result word is written into the output buffer and reaches m_* from there.
// Throughput: one byte per cycle; the parser updates its state on every accepted byte
// and s_tready drops only while both slots of the output buffer hold words.
// Reset (rst_n, async, active low): hunt for flag, last sequence 1, info not blocked.
// Depends on sfr_pkg, sfr_parser and sfr_out_buf.
module stuffed_frame_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,     // info_blocked
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,      // data_byte[7:0], frame_kind[9:8], seq_number[10],
                                      // payload_length[21:11], reply[24:22], zero[31:25]
    output logic [2:0]  m_tuser       // event_res
);
    import sfr_pkg::*;

    sfr_result_t res;
    sfr_item_t   out_item;
    logic        buf_full;
    logic        in_fire;

    assign cfg_ready = 1'b1;
    assign s_tready  = !buf_full;
    assign in_fire   = s_tvalid && s_tready;

    sfr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_we  (cfg_valid),
        .cfg_bit (cfg_data),
        .in_fire (in_fire),
        .rx_byte (s_tdata),
        .res     (res)
    );

    sfr_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res.valid),
        .push_item (res.item),
        .full      (buf_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tuser = out_item.event_res;
    assign m_tdata = {7'd0, out_item.reply, out_item.payload_length, out_item.seq_number,
                      out_item.frame_kind, out_item.data_byte};

endmodule

### hdl/sfr_parser.sv
// Per-byte frame parser: header check, destuffing, BCC checks, result build.
// Depends on sfr_pkg.
module sfr_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_bit,
    input  logic                in_fire,
    input  logic [7:0]          rx_byte,
    output sfr_pkg::sfr_result_t res
);
    import sfr_pkg::*;

    localparam logic [2:0] ST_HUNT    = 3'd0;
    localparam logic [2:0] ST_FLAG    = 3'd1;
    localparam logic [2:0] ST_ADDR    = 3'd2;
    localparam logic [2:0] ST_CTRL    = 3'd3;
    localparam logic [2:0] ST_SUP_END = 3'd4;
    localparam logic [2:0] ST_DATA    = 3'd5;
    localparam logic [2:0] ST_ESC     = 3'd6;

    logic             blocked_reg, blocked_next;
    logic [2:0]       state_reg, state_next;
    logic [7:0]       control_reg, control_next;
    logic [7:0]       xor_reg, xor_next;
    logic [7:0]       held_reg, held_next;
    logic             held_valid_reg, held_valid_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic             last_seq_reg, last_seq_next;

    logic       seq;
    logic       is_info;
    logic       do_push;
    logic       do_err;
    logic [7:0] push_d;

    assign seq     = control_reg[6];
    assign is_info = (control_reg == CTRL_I0) || (control_reg == CTRL_I1);
    assign blocked_next = cfg_we ? cfg_bit : blocked_reg;

    always_comb
    begin
        state_next      = state_reg;
        control_next    = control_reg;
        xor_next        = xor_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        count_next      = count_reg;
        last_seq_next   = last_seq_reg;
        res             = '0;
        do_push         = 1'b0;
        do_err          = 1'b0;
        push_d          = rx_byte;

        if (in_fire)
        begin
            unique case (state_reg)
                ST_HUNT:
                begin
                    if (rx_byte == FLAG_BYTE)
                        state_next = ST_FLAG;
                end
                ST_FLAG:
                begin
                    if (rx_byte == ADDR_BYTE)
                        state_next = ST_ADDR;
                    else if (rx_byte != FLAG_BYTE)
                        state_next = ST_HUNT;
                end
                ST_ADDR:
                begin
                    if (rx_byte == CTRL_SET || rx_byte == CTRL_UA || rx_byte == CTRL_DISC ||
                        rx_byte == CTRL_I0 || rx_byte == CTRL_I1)
                    begin
                        control_next = rx_byte;
                        state_next   = ST_CTRL;
                    end
                    else if (rx_byte == FLAG_BYTE)
                        state_next = ST_FLAG;
                    else
                        state_next = ST_HUNT;
                end
                ST_CTRL:
                begin
                    if (is_info && blocked_reg)
                    begin
                        // blocked: report whatever the BCC1 byte is, no reply
                        state_next               = ST_HUNT;
                        res.valid                = 1'b1;
                        res.item.event_res       = EV_INFO_ERR;
                        res.item.seq_number      = seq;
                        res.item.reply           = REP_NONE;
                    end
                    else if (rx_byte == (ADDR_BYTE ^ control_reg))
                    begin
                        if (!is_info)
                            state_next = ST_SUP_END;
                        else if (seq == last_seq_reg)
                        begin
                            state_next          = ST_HUNT;
                            res.valid           = 1'b1;
                            res.item.event_res  = EV_DUP;
                            res.item.seq_number = seq;
                            res.item.reply      = seq ? REP_RR0 : REP_RR1;
                        end
                        else
                        begin
                            xor_next        = '0;
                            held_next       = '0;
                            held_valid_next = 1'b0;
                            count_next      = '0;
                            state_next      = ST_DATA;
                        end
                    end
                    else if (rx_byte == FLAG_BYTE)
                        state_next = ST_FLAG;
                    else
                        state_next = ST_HUNT;
                end
                ST_SUP_END:
                begin
                    state_next = ST_HUNT;
                    if (rx_byte == FLAG_BYTE)
                    begin
                        res.valid          = 1'b1;
                        res.item.event_res = EV_SUP_OK;
                        if (control_reg == CTRL_SET)
                        begin
                            res.item.frame_kind = KIND_SET;
                            res.item.reply      = REP_UA;
                        end
                        else
                            res.item.frame_kind = (control_reg == CTRL_UA) ? KIND_UA : KIND_DISC;
                    end
                end
                ST_DATA:
                begin
                    if (rx_byte == FLAG_BYTE)
                    begin
                        // the held byte is the BCC2
                        if (!held_valid_reg || held_reg != xor_reg)
                            do_err = 1'b1;
                        else
                        begin
                            state_next              = ST_HUNT;
                            last_seq_next           = seq;
                            res.valid               = 1'b1;
                            res.item.event_res      = EV_INFO_OK;
                            res.item.seq_number     = seq;
                            res.item.payload_length = count_reg;
                            res.item.reply          = seq ? REP_RR0 : REP_RR1;
                        end
                    end
                    else if (rx_byte == ESC_BYTE)
                        state_next = ST_ESC;
                    else
                        do_push = 1'b1;
                end
                ST_ESC:
                begin
                    if (rx_byte == ESC_FLAG)
                    begin
                        do_push = 1'b1;
                        push_d  = FLAG_BYTE;
                    end
                    else if (rx_byte == ESC_ESC)
                    begin
                        do_push = 1'b1;
                        push_d  = ESC_BYTE;
                    end
                    else
                        do_err = 1'b1;
                end
                default:
                    state_next = ST_HUNT;
            endcase

            // release the held byte, hold the new one
            if (do_push)
            begin
                if (held_valid_reg && count_reg >= LEN_W'(MAX_PAYLOAD))
                    do_err = 1'b1;
                else
                begin
                    if (held_valid_reg)
                    begin
                        res.valid          = 1'b1;
                        res.item.event_res = EV_DATA;
                        res.item.data_byte = held_reg;
                        xor_next           = xor_reg ^ held_reg;
                        count_next         = count_reg + 1'b1;
                    end
                    held_next       = push_d;
                    held_valid_next = 1'b1;
                    state_next      = ST_DATA;
                end
            end

            if (do_err)
            begin
                state_next          = ST_HUNT;
                res                 = '0;
                res.valid           = 1'b1;
                res.item.event_res  = EV_INFO_ERR;
                res.item.seq_number = seq;
                res.item.reply      = seq ? REP_REJ1 : REP_REJ0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocked_reg    <= 1'b0;
            state_reg      <= ST_HUNT;
            control_reg    <= '0;
            xor_reg        <= '0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            count_reg      <= '0;
            last_seq_reg   <= 1'b1;
        end
        else
        begin
            blocked_reg    <= blocked_next;
            state_reg      <= state_next;
            control_reg    <= control_next;
            xor_reg        <= xor_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            count_reg      <= count_next;
            last_seq_reg   <= last_seq_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LEN_W'(MAX_PAYLOAD))
        else $error("payload count beyond maximum");

    a_data_from_payload: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.item.event_res == EV_DATA |->
            (state_reg == ST_DATA || state_reg == ST_ESC) && held_valid_reg)
        else $error("data word outside payload");

    a_ok_sets_seq: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.item.event_res == EV_INFO_OK |=>
            last_seq_reg == $past(seq) && state_reg == ST_HUNT)
        else $error("accepted frame did not update sequence");

endmodule

### hdl/sfr_out_buf.sv
// Two-entry result buffer between the parser and the output stream.
// Depends on sfr_pkg.
module sfr_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sfr_pkg::sfr_item_t push_item,
    output logic              full,
    output logic              out_valid,
    input  logic              out_ready,
    output sfr_pkg::sfr_item_t out_item
);
    import sfr_pkg::*;

    sfr_item_t  mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg != 2'd2)
        else $error("result buffer overflow");

    a_count_tracks_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg))
        else $error("buffer count and pointers disagree");

endmodule
